[hdl/json_comment_stripper_macros.svh]
// ---------------------------------------------------------------------------
// json_comment_stripper_macros.svh
// Assertion macros shared by the comment stripper RTL.
// ---------------------------------------------------------------------------
`ifndef JSON_COMMENT_STRIPPER_MACROS_SVH
`define JSON_COMMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/jcs_pkg.sv]
// ---------------------------------------------------------------------------
// jcs_pkg
// Types, character codes and per-byte classification functions of the
// JSON comment stripper.
// ---------------------------------------------------------------------------
package jcs_pkg;

	// Characters the scanner reacts to.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_NONE   = 8'h00;

	// Configuration port geometry and register indexes.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_KEEP_LAYOUT = '0;

	// Result queue depth; one transaction may push two results.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_NONE  = 3'b001,
		MODE_LINE  = 3'b010,
		MODE_BLOCK = 3'b100
	} cmt_mode_t;

	// Scanner state carried from byte to byte within one text.
	typedef struct packed {
		cmt_mode_t   mode;
		logic        quoted;
		logic [7:0]  prev;
		logic [7:0]  pprev;
		logic [1:0]  pos;
	} text_state_t;

	localparam text_state_t TEXT_STATE_RESET = '{
		mode:   MODE_NONE,
		quoted: 1'b0,
		prev:   8'h00,
		pprev:  8'h00,
		pos:    2'd0
	};

	// Outcome of deciding one byte against its successor.
	typedef struct packed {
		text_state_t st;
		logic        cmt;
		logic        skip;
		logic        ncmt;
	} decide_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} emit_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
	endfunction

	// Shift a decided byte into the history and bump the saturating position.
	function automatic text_state_t advance(text_state_t s, logic [7:0] c);
		text_state_t r;
		r = s;
		r.pprev = s.prev;
		r.prev = c;
		if (s.pos != 2'd2) begin
			r.pos = s.pos + 2'd1;
		end
		return r;
	endfunction

	// Classify byte cur given its successor nxt (zero when the text ends).
	function automatic decide_t decide(text_state_t s, logic [7:0] cur, logic [7:0] nxt);
		decide_t d;
		logic    esc;
		d.st = s;
		d.cmt = 1'b0;
		d.skip = 1'b0;
		d.ncmt = 1'b0;
		// A quote is escaped by a single backslash, never in the first two bytes.
		esc = (s.pos == 2'd2) && (s.prev == CH_BSLASH) && (s.pprev != CH_BSLASH);
		if ((s.mode == MODE_NONE) && (cur == CH_QUOTE) && !esc) begin
			d.st.quoted = !s.quoted;
		end
		if (d.st.quoted) begin
			d.cmt = 1'b0;
		end else if ((s.mode == MODE_NONE) && (cur == CH_SLASH) && (nxt == CH_SLASH)) begin
			d.st.mode = MODE_LINE;
			d.skip = 1'b1;
			d.ncmt = 1'b1;
			d.cmt = 1'b1;
		end else if ((s.mode == MODE_LINE) && (cur == CH_CR) && (nxt == CH_LF)) begin
			// The CR of a CRLF belongs to the comment; the LF is text.
			d.st.mode = MODE_NONE;
			d.skip = 1'b1;
			d.cmt = 1'b1;
		end else if ((s.mode == MODE_LINE) && (cur == CH_LF)) begin
			d.st.mode = MODE_NONE;
		end else if ((s.mode == MODE_NONE) && (cur == CH_SLASH) && (nxt == CH_STAR)) begin
			d.st.mode = MODE_BLOCK;
			d.skip = 1'b1;
			d.ncmt = 1'b1;
			d.cmt = 1'b1;
		end else if ((s.mode == MODE_BLOCK) && (cur == CH_STAR) && (nxt == CH_SLASH)) begin
			d.st.mode = MODE_NONE;
			d.skip = 1'b1;
			d.ncmt = 1'b1;
			d.cmt = 1'b1;
		end else begin
			d.cmt = (s.mode != MODE_NONE);
		end
		d.st = advance(d.st, cur);
		return d;
	endfunction

	// Turn a classified byte into a result: text passes, comments drop or blank.
	function automatic emit_t emit(logic keep, logic [7:0] c, logic cmt);
		emit_t e;
		e.valid = !cmt || keep;
		e.item.data = (cmt && !is_ws(c)) ? CH_SPACE : c;
		e.item.last = 1'b0;
		return e;
	endfunction

endpackage

[hdl/json_comment_stripper.sv]
// ---------------------------------------------------------------------------
// json_comment_stripper
// Streaming removal of line and block comments from a JSON text.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle and holds one byte of lookahead, so each
// transaction yields zero, one or two output bytes, which enter a four-entry
// result queue and leave one per cycle while out_ready is high. in_ready is
// high while the queue has at least two free entries, so input runs at one
// byte per cycle as long as the output side drains the text, which is at most
// one byte per cycle. The user writes keep_layout over the APB port only while
// the stream is idle; the block itself does not enforce this.

`include "json_comment_stripper_macros.svh"

module json_comment_stripper
	import jcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	// Output stream
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last,
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic                  keep_q;
	logic [7:0]            held_q;
	logic                  held_valid_q;
	text_state_t           state_q;
	out_item_t             queue_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0]     count_q;

	logic                  in_acc;
	logic                  out_acc;
	logic                  reg_sel;
	logic [7:0]            held_d;
	logic                  held_valid_d;
	text_state_t           state_d;
	emit_t                 res_a;
	emit_t                 res_b;
	out_item_t             first_item;
	out_item_t             second_item;
	logic [1:0]            push_n;
	out_item_t             shifted [QUEUE_DEPTH];
	out_item_t             queue_d [QUEUE_DEPTH];
	logic [QCNT_W-1:0]     base;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_KEEP_LAYOUT);
	assign prdata  = reg_sel ? {{(APB_DATA_W-1){1'b0}}, keep_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			keep_q <= pwdata[0];
		end
	end

	// Decide the held byte against the incoming one, and close the text on
	// its final byte.
	always_comb begin
		decide_t     d_held;
		decide_t     d_final;
		text_state_t s_mid;
		emit_t       e_skip;
		emit_t       e_final;
		logic [7:0]  held_mid;
		logic        hv_mid;

		res_a = '0;
		e_skip = '0;
		e_final = '0;
		s_mid = state_q;
		held_mid = in_byte;
		hv_mid = 1'b1;
		d_held = decide(state_q, held_q, in_byte);
		if (held_valid_q) begin
			res_a = emit(keep_q, held_q, d_held.cmt);
			s_mid = d_held.st;
			if (d_held.skip) begin
				e_skip = emit(keep_q, in_byte, d_held.ncmt);
				s_mid = advance(d_held.st, in_byte);
				hv_mid = 1'b0;
			end
		end

		d_final = decide(s_mid, held_mid, CH_NONE);
		if (in_last && hv_mid) begin
			e_final = emit(keep_q, held_mid, d_final.cmt);
		end

		res_b = e_skip.valid ? e_skip : e_final;

		if (in_last) begin
			held_d = 8'h00;
			held_valid_d = 1'b0;
			state_d = TEXT_STATE_RESET;
		end else begin
			held_d = held_mid;
			held_valid_d = hv_mid;
			state_d = s_mid;
		end

		// Pack results to the front; the final one carries the end mark.
		first_item = res_a.valid ? res_a.item : res_b.item;
		second_item = res_b.item;
		push_n = {1'b0, res_a.valid} + {1'b0, res_b.valid};
		if (push_n == 2'd2) begin
			second_item.last = in_last;
		end else begin
			first_item.last = in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'h00;
			held_valid_q <= 1'b0;
			state_q <= TEXT_STATE_RESET;
		end else if (in_acc) begin
			held_q <= held_d;
			held_valid_q <= held_valid_d;
			state_q <= state_d;
		end
	end

	// Result queue: the head sits at entry zero, new results land behind the
	// entries that remain after this cycle's pop.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			shifted[i] = queue_q[i + 1];
		end
		shifted[QUEUE_DEPTH-1] = queue_q[QUEUE_DEPTH-1];
		base = count_q - {{(QCNT_W-1){1'b0}}, out_acc};
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_d[i] = out_acc ? shifted[i] : queue_q[i];
			if (in_acc && (push_n != 2'd0) && (QCNT_W'(i) == base)) begin
				queue_d[i] = first_item;
			end
			if (in_acc && (push_n == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1))) begin
				queue_d[i] = second_item;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_q[i] <= queue_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + (in_acc ? QCNT_W'(push_n) : '0);
		end
	end

	assign in_ready  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_byte  = queue_q[0].data;
	assign out_last  = queue_q[0].last;

	// Checks on the queue and the end-of-text handling.
	`JCS_ASSERT_IMPLY(a_queue_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "result queue overflow")
	`JCS_ASSERT_NEXT(a_last_clears, clk, arst_n, in_acc && in_last, !held_valid_q && (state_q.mode == MODE_NONE) && !state_q.quoted, "text state not cleared after final byte")
	`JCS_ASSERT_NEXT(a_no_phantom, clk, arst_n, !in_acc, count_q <= $past(count_q), "results appeared without an input transaction")
	`JCS_ASSERT_NEXT(a_keep_emits, clk, arst_n, in_acc && keep_q && (held_valid_q || in_last), count_q >= $past(count_q), "keep_layout transaction produced no result")

endmodule
